// ===== rtl/lls_pkg.sv =====
// Shared constants, types and the rule function for the life-like automaton stencil.
`default_nettype none

package lls_pkg;

  // Grid geometry
  localparam int unsigned GRID_WIDTH  = 128;
  localparam int unsigned GRID_HEIGHT = 128;
  localparam int unsigned COL_W       = $clog2(GRID_WIDTH);
  localparam int unsigned ROW_W       = $clog2(GRID_HEIGHT);

  // Result field widths
  localparam int unsigned OUT_W  = 7;
  localparam int unsigned RULE_W = 4;
  localparam int unsigned CNT_W  = 4;

  // Output queue depth
  localparam int unsigned FIFO_DEPTH = 3;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Last column and row of the grid and of the interior
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_HEIGHT - 1);
  localparam logic [OUT_W-1:0] OUT_COL_LAST = OUT_W'(GRID_WIDTH - 2);
  localparam logic [OUT_W-1:0] OUT_ROW_LAST = OUT_W'(GRID_HEIGHT - 2);

  // Rule codes
  localparam logic [RULE_W-1:0] RULE_LIFE       = 4'd0;
  localparam logic [RULE_W-1:0] RULE_HIGHLIFE   = 4'd1;
  localparam logic [RULE_W-1:0] RULE_PEDESTRIAN = 4'd2;
  localparam logic [RULE_W-1:0] RULE_GEOLOGY    = 4'd3;
  localparam logic [RULE_W-1:0] RULE_DIAMOEBA   = 4'd4;
  localparam logic [RULE_W-1:0] RULE_HOLSTEIN   = 4'd5;
  localparam logic [RULE_W-1:0] RULE_CORAL      = 4'd6;
  localparam logic [RULE_W-1:0] RULE_VOTE       = 4'd7;
  localparam logic [RULE_W-1:0] RULE_LANDRUSH   = 4'd8;
  localparam logic [RULE_W-1:0] RULE_MAZECTRIC  = 4'd9;

  // Item in flight between the read and the write-back stage
  typedef struct packed {
    logic             valid;
    logic             produce;
    logic             last;
    logic             cell_bit;
    logic [COL_W-1:0] col;
    logic [OUT_W-1:0] out_row;
    logic [OUT_W-1:0] out_col;
  } lls_stage_t;

  // One result beat
  typedef struct packed {
    logic             next_alive;
    logic [OUT_W-1:0] cell_row;
    logic [OUT_W-1:0] cell_col;
    logic             last;
  } lls_res_t;

  // Birth/survival decision for neighbor count n and current state a
  function automatic logic apply_rule(input logic [RULE_W-1:0] rule,
                                      input logic [CNT_W-1:0] n,
                                      input logic a);
    logic r;
    r = 1'b0;
    case (rule)
      RULE_LIFE:       r = (n == 4'd3) || (n == 4'd2 && a);
      RULE_HIGHLIFE:   r = (n == 4'd3) || (n == 4'd2 && a) || (n == 4'd6 && !a);
      RULE_PEDESTRIAN: r = (n == 4'd3) || (n == 4'd2 && a) || (n == 4'd8 && !a);
      RULE_GEOLOGY:    r = (n > 4'd6) || ((n inside {4'd3, 4'd5}) && !a) ||
                           ((n inside {4'd2, 4'd4, 4'd6}) && a);
      RULE_DIAMOEBA:   r = (n > 4'd4) || (n == 4'd3 && !a);
      RULE_HOLSTEIN:   r = (n > 4'd5) || ((n inside {4'd3, 4'd5}) && !a) ||
                           (n == 4'd4 && a);
      RULE_CORAL:      r = (n == 4'd3 && !a) || (n > 4'd3 && a);
      RULE_VOTE:       r = (n + CNT_W'(a)) > 4'd4;
      RULE_LANDRUSH:   r = (n inside {4'd3, 4'd5}) || (n > 4'd1 && n != 4'd6 && a);
      RULE_MAZECTRIC:  r = (n == 4'd3) || ((n inside {[4'd1:4'd4]}) && a);
      default:         r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lls_line_mem.sv =====
// Two-row line buffer memory: one entry per column holds {row above, row two above}.
`default_nettype none

module lls_line_mem (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [lls_pkg::COL_W-1:0] rd_addr_i,
  output logic [1:0]                rd_data_o,
  input  logic                      wr_en_i,
  input  logic [lls_pkg::COL_W-1:0] wr_addr_i,
  input  logic [1:0]                wr_data_i
);
  import lls_pkg::*;

  logic [1:0] mem_q [GRID_WIDTH];
  logic [1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/lls_window.sv =====
// Write-back stage: shifts the 3x3 window, updates the line buffers, applies the rule.
`default_nettype none

module lls_window (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lls_pkg::lls_stage_t        stage_i,
  input  logic [1:0]                 rd_data_i,
  input  logic [lls_pkg::RULE_W-1:0] rule_i,
  output logic                       wr_en_o,
  output logic [lls_pkg::COL_W-1:0]  wr_addr_o,
  output logic [1:0]                 wr_data_o,
  output logic                       push_o,
  output lls_pkg::lls_res_t          res_o
);
  import lls_pkg::*;

  logic [8:0]       window_q, window_d;
  logic [2:0]       new_col;
  logic             center;
  logic [CNT_W-1:0] neighbors;

  // Build the incoming column: top, middle, new cell
  assign new_col  = {stage_i.cell_bit, rd_data_i[1], rd_data_i[0]};
  assign window_d = {new_col, window_q[8:3]};

  // Shift window by one column per beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (stage_i.valid) begin
      window_q <= window_d;
    end
  end

  // Age the column: middle moves to two-above, new cell to above
  assign wr_en_o   = stage_i.valid;
  assign wr_addr_o = stage_i.col;
  assign wr_data_o = {stage_i.cell_bit, rd_data_i[1]};

  // Count the eight neighbors around the center
  assign center    = window_d[4];
  assign neighbors = CNT_W'(window_d[0]) + CNT_W'(window_d[1]) + CNT_W'(window_d[2]) +
                     CNT_W'(window_d[3]) + CNT_W'(window_d[5]) + CNT_W'(window_d[6]) +
                     CNT_W'(window_d[7]) + CNT_W'(window_d[8]);

  assign push_o           = stage_i.valid && stage_i.produce;
  assign res_o.next_alive = apply_rule(rule_i, neighbors, center);
  assign res_o.cell_row   = stage_i.out_row;
  assign res_o.cell_col   = stage_i.out_col;
  assign res_o.last       = stage_i.last;

endmodule

`default_nettype wire

// ===== rtl/lls_out_fifo.sv =====
// Small result queue that decouples the stencil from output stalls.
`default_nettype none

module lls_out_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  lls_pkg::lls_res_t              push_data_i,
  input  logic                           pop_i,
  output lls_pkg::lls_res_t              head_o,
  output logic [lls_pkg::FIFO_CNT_W-1:0] count_o
);
  import lls_pkg::*;

  lls_res_t              entry_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;

  function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
    logic [FIFO_PTR_W-1:0] n;
    n = (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + FIFO_CNT_W'(push_i) - FIFO_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the result beat
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

`default_nettype wire

// ===== rtl/life_like_automaton_stencil.sv =====
// Top level of the life-like automaton stencil: position counters, line memory, window, queue.
//
//   channel   dir  handshake                       payload
//   input     in   in_valid_i / in_stall_o         cell_alive_i
//   output    out  out_valid_o / out_stall_i       next_alive_o, cell_row_o, cell_col_o,
//                                                  last_of_generation_o
//   config    in   rule_select_we_i                rule_select_i
//
// One cell per clock sustained while the output is not stalled. A cell is read from the
// line memory in its accept cycle and written back in the cycle after; a produced result
// enters a three-entry queue and shows on the output. The next row reads a column a full
// row after its write, so read and write never meet on one entry. No clearing pass after
// reset: counters and window reset, the line memory fills during the first two rows.
// in_stall_o rises only when the queue plus the item in flight would fill it.
`default_nettype none

module life_like_automaton_stencil (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       cell_alive_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       next_alive_o,
  output logic [lls_pkg::OUT_W-1:0]  cell_row_o,
  output logic [lls_pkg::OUT_W-1:0]  cell_col_o,
  output logic                       last_of_generation_o,
  input  logic                       rule_select_we_i,
  input  logic [lls_pkg::RULE_W-1:0] rule_select_i
);
  import lls_pkg::*;

  logic [RULE_W-1:0]     rule_q;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [COL_W-1:0]      col_q, col_d;
  lls_stage_t            stage_q, stage_d;
  logic                  in_accept;
  logic [1:0]            rd_data;
  logic                  wr_en;
  logic [COL_W-1:0]      wr_addr;
  logic [1:0]            wr_data;
  logic                  push;
  lls_res_t              push_res;
  lls_res_t              head;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FIFO_CNT_W:0]   pending;
  logic                  pop;
  logic                  ring;

  // Rule register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_q <= RULE_LIFE;
    end else if (rule_select_we_i) begin
      rule_q <= rule_select_i;
    end
  end

  // Hold input while queue plus item in flight could fill the queue
  assign pending    = (FIFO_CNT_W + 1)'(fifo_count) + (FIFO_CNT_W + 1)'(stage_q.valid);
  assign in_stall_o = pending >= (FIFO_CNT_W + 1)'(FIFO_DEPTH);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Advance raster position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_accept) begin
      if (col_q == COL_LAST) begin
        col_d = '0;
        row_d = (row_q == ROW_LAST) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Tag the accepted cell for the write-back stage
  assign ring = (row_q == '0) || (row_q == ROW_LAST) || (col_q == '0) || (col_q == COL_LAST);

  always_comb begin
    stage_d.valid    = in_accept;
    stage_d.produce  = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
    stage_d.last     = (row_q == ROW_LAST) && (col_q == COL_LAST);
    stage_d.cell_bit = cell_alive_i && !ring;
    stage_d.col      = col_q;
    stage_d.out_row  = OUT_W'(row_q - 1'b1);
    stage_d.out_col  = OUT_W'(col_q - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  lls_line_mem u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (in_accept),
    .rd_addr_i (col_q),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  lls_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (stage_q),
    .rd_data_i (rd_data),
    .rule_i    (rule_q),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .push_o    (push),
    .res_o     (push_res)
  );

  assign pop = out_valid_o && !out_stall_i;

  lls_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_res),
    .pop_i       (pop),
    .head_o      (head),
    .count_o     (fifo_count)
  );

  // Drive output beat from queue head
  assign out_valid_o          = fifo_count != '0;
  assign next_alive_o         = head.next_alive;
  assign cell_row_o           = head.cell_row;
  assign cell_col_o           = head.cell_col;
  assign last_of_generation_o = head.last;

endmodule

`default_nettype wire

// ===== rtl/lls_checker.sv =====
// Port-level checks for the life-like automaton stencil, bound to the top level.
`default_nettype none

module lls_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       next_alive_o,
  input logic [lls_pkg::OUT_W-1:0]  cell_row_o,
  input logic [lls_pkg::OUT_W-1:0]  cell_col_o,
  input logic                       last_of_generation_o
);
  import lls_pkg::*;

  logic in_beat;
  logic out_beat;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_o && !out_stall_i;

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(next_alive_o) && $stable(cell_row_o) &&
       $stable(cell_col_o) && $stable(last_of_generation_o)))
    else $error("stalled result beat changed");

  // Last-of-generation marks the bottom-right interior cell
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_generation_o) |->
      (cell_row_o == OUT_ROW_LAST && cell_col_o == OUT_COL_LAST))
    else $error("last flag on wrong cell");

  // Back-to-back beats inside a row step the column by one
  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && $past(out_beat) && $past(cell_col_o) != OUT_COL_LAST) |->
      (cell_col_o == $past(cell_col_o) + 1'b1))
    else $error("column did not advance");

  // An empty output comes alive only from an earlier accepted input beat
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_beat, 2))
    else $error("result without input beat");

endmodule

bind life_like_automaton_stencil lls_checker u_lls_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_stall_o           (in_stall_o),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .next_alive_o         (next_alive_o),
  .cell_row_o           (cell_row_o),
  .cell_col_o           (cell_col_o),
  .last_of_generation_o (last_of_generation_o)
);

`default_nettype wire
